// File: sv/cfb_pkg.sv
package cfb_pkg;

  localparam int MAX_DATA = 33;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int PC_W   = 4;

  localparam logic [BYTE_W-1:0] HDR_A = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_B = 8'hAA;
  localparam logic [BYTE_W-1:0] TRL_A = 8'hF0;
  localparam logic [BYTE_W-1:0] TRL_B = 8'h0F;
  localparam logic [BYTE_W-1:0] FILL  = 8'h00;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_t;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_START = 4'd0;
  localparam pc_t PC_FILL  = 4'd7;
  localparam pc_t PC_CLOSE = 4'd8;
  localparam pc_t PC_OPEN  = 4'd11;
  localparam pc_t PC_DATA  = 4'd12;

  typedef enum logic [3:0] {
    SRC_HDR_A,
    SRC_HDR_B,
    SRC_RW,
    SRC_MCMD,
    SRC_SCMD,
    SRC_LEN,
    SRC_FILL,
    SRC_DATA,
    SRC_CHECK,
    SRC_TRL_A,
    SRC_TRL_B
  } src_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_WRITE_OPEN,
    COND_FILL_DONE,
    COND_CLOSE_NOW
  } cond_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DEC,
    ACT_SET_OPEN,
    ACT_CLOSE
  } act_t;

  typedef enum logic [1:0] {
    NX_INC,
    NX_STAY,
    NX_DONE
  } nx_t;

  typedef struct packed {
    logic  emit;
    src_t  src;
    logic  last;
    act_t  act;
    cond_t cond;
    pc_t   target;
    nx_t   nx;
  } ucode_t;

  typedef struct packed {
    logic write_open;
    logic fill_done;
    logic close_now;
  } flags_t;

  function automatic ucode_t uc(logic emit, src_t src, logic last, act_t act,
                                cond_t cond, pc_t target, nx_t nx);
    ucode_t w;
    w.emit   = emit;
    w.src    = src;
    w.last   = last;
    w.act    = act;
    w.cond   = cond;
    w.target = target;
    w.nx     = nx;
    return w;
  endfunction

  // control store
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = uc(1'b1, SRC_HDR_A, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd1:    w = uc(1'b1, SRC_HDR_B, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd2:    w = uc(1'b1, SRC_RW, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd3:    w = uc(1'b1, SRC_MCMD, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd4:    w = uc(1'b1, SRC_SCMD, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd5:    w = uc(1'b1, SRC_LEN, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd6:    w = uc(1'b0, SRC_FILL, 1'b0, ACT_NONE, COND_WRITE_OPEN, PC_OPEN, NX_INC);
      4'd7:    w = uc(1'b1, SRC_FILL, 1'b0, ACT_DEC, COND_FILL_DONE, PC_CLOSE, NX_STAY);
      4'd8:    w = uc(1'b1, SRC_CHECK, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd9:    w = uc(1'b1, SRC_TRL_A, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_INC);
      4'd10:   w = uc(1'b1, SRC_TRL_B, 1'b1, ACT_CLOSE, COND_NONE, PC_START, NX_DONE);
      4'd11:   w = uc(1'b0, SRC_FILL, 1'b0, ACT_SET_OPEN, COND_NONE, PC_START, NX_DONE);
      4'd12:   w = uc(1'b1, SRC_DATA, 1'b0, ACT_DEC, COND_NONE, PC_START, NX_INC);
      4'd13:   w = uc(1'b0, SRC_FILL, 1'b0, ACT_NONE, COND_CLOSE_NOW, PC_CLOSE, NX_DONE);
      default: w = uc(1'b0, SRC_FILL, 1'b0, ACT_NONE, COND_NONE, PC_START, NX_DONE);
    endcase
    return w;
  endfunction

endpackage

// File: sv/cfb_sequencer.sv
module cfb_sequencer
  import cfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   launch,
  input  pc_t    entry,
  input  flags_t flags,
  input  logic   out_free,
  output logic   busy,
  output logic   fire,
  output ucode_t word
);

  logic busy_r, busy_nxt;
  pc_t  pc_r, pc_nxt;
  logic cond_hit;

  assign word = ucode_rom(pc_r);
  assign busy = busy_r;

  always_comb begin
    unique case (word.cond)
      COND_NONE:       cond_hit = 1'b0;
      COND_WRITE_OPEN: cond_hit = flags.write_open;
      COND_FILL_DONE:  cond_hit = flags.fill_done;
      COND_CLOSE_NOW:  cond_hit = flags.close_now;
      default:         cond_hit = 1'b0;
    endcase
  end

  assign fire = busy_r && !cond_hit && (!word.emit || out_free);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (launch) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry;
    end else if (busy_r && cond_hit) begin
      pc_nxt = word.target;
    end else if (fire) begin
      unique case (word.nx)
        NX_INC:  pc_nxt = pc_r + 1'b1;
        NX_STAY: pc_nxt = pc_r;
        NX_DONE: busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_START;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

// File: sv/command_frame_builder.sv
// Command frame builder. A start transfer (opcode 0) sends the header 55 AA, rw flag,
// main command, sub command and length; a read frame (rw flag zero) follows with that many
// zero bytes, then checksum, F0 and 0F. A write frame with nonzero length stays open and
// each data transfer (opcode 1) sends its byte, the last one also checksum and trailer.
// The checksum makes all frame bytes sum to zero mod 256. Starts with a length above
// MAX_DATA and data while no frame is open are taken and dropped. out_frame_end marks the
// final 0F. Items are taken one at a time: a microcoded sequencer sends the bytes through
// the output register, holding while the output is stalled, and after a transfer in_stall
// stays high until the sequencer has finished the write start, read start, data byte or
// data byte that closes the frame, also through any output stall.
module command_frame_builder
  import cfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [BYTE_W-1:0] in_rw_flag,
  input  logic [BYTE_W-1:0] in_main_command,
  input  logic [BYTE_W-1:0] in_sub_command,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [BYTE_W-1:0] in_payload_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_frame_end
);

  logic              busy, fire, launch, accept, out_free;
  pc_t               entry;
  ucode_t            word;
  flags_t            flags;
  logic [BYTE_W-1:0] sel_byte;

  logic [BYTE_W-1:0] rw_r, mcmd_r, scmd_r, data_r;
  logic [LEN_W-1:0]  len_r;
  logic              open_r, open_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  assign accept   = in_valid && !busy;
  assign in_stall = busy;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    launch = 1'b0;
    entry  = PC_START;
    if (accept) begin
      if (in_opcode == OP_START) begin
        launch = (32'(in_payload_length) <= MAX_DATA);
      end else begin
        launch = open_r && (left_r != '0);
        entry  = PC_DATA;
      end
    end
  end

  assign flags.write_open = (rw_r != '0) && (len_r != '0);
  assign flags.fill_done  = (rw_r != '0) || (left_r == '0);
  assign flags.close_now  = (left_r == '0);

  cfb_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .launch   (launch),
    .entry    (entry),
    .flags    (flags),
    .out_free (out_free),
    .busy     (busy),
    .fire     (fire),
    .word     (word)
  );

  always_comb begin
    case (word.src)
      SRC_HDR_A: sel_byte = HDR_A;
      SRC_HDR_B: sel_byte = HDR_B;
      SRC_RW:    sel_byte = rw_r;
      SRC_MCMD:  sel_byte = mcmd_r;
      SRC_SCMD:  sel_byte = scmd_r;
      SRC_LEN:   sel_byte = BYTE_W'(len_r);
      SRC_DATA:  sel_byte = data_r;
      // checksum over the bytes so far plus both trailer bytes
      SRC_CHECK: sel_byte = BYTE_W'(0) - (sum_r + TRL_A + TRL_B);
      SRC_TRL_A: sel_byte = TRL_A;
      SRC_TRL_B: sel_byte = TRL_B;
      default:   sel_byte = FILL;
    endcase
  end

  always_comb begin
    open_nxt      = open_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (launch && (in_opcode == OP_START)) begin
      open_nxt = 1'b0;
      left_nxt = in_payload_length;
      sum_nxt  = '0;
    end else if (fire) begin
      if (word.emit) begin
        sum_nxt       = sum_r + sel_byte;
        out_valid_nxt = 1'b1;
      end
      case (word.act)
        ACT_DEC:      left_nxt = left_r - 1'b1;
        ACT_SET_OPEN: open_nxt = 1'b1;
        ACT_CLOSE: begin
          open_nxt = 1'b0;
          left_nxt = '0;
          sum_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      left_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      open_r      <= open_nxt;
      left_r      <= left_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rw_r   <= in_rw_flag;
      mcmd_r <= in_main_command;
      scmd_r <= in_sub_command;
      len_r  <= in_payload_length;
      data_r <= in_payload_byte;
    end
    if (fire && word.emit) begin
      out_byte_r <= sel_byte;
      out_end_r  <= word.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule

// File: sim/frame_checker.sv
module frame_checker
  import cfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_opcode,
  input  logic [BYTE_W-1:0] in_rw_flag,
  input  logic [BYTE_W-1:0] in_main_command,
  input  logic [BYTE_W-1:0] in_sub_command,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [BYTE_W-1:0] in_payload_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_frame_end,
  output int                fail_count,
  output int                pending_bytes,
  output int                bytes_checked,
  output int                frames_closed
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } wire_byte_t;

  wire_byte_t        wire_bytes_q[$];
  logic              frame_open;
  logic [LEN_W-1:0]  data_left;
  logic [BYTE_W-1:0] byte_sum;
  wire_byte_t        oldest;

  function automatic void queue_summed(logic [BYTE_W-1:0] b);
    wire_bytes_q.push_back('{value: b, last: 1'b0});
    byte_sum = byte_sum + b;
  endfunction

  // checksum slot counts as zero, so it balances header, data and trailer
  function automatic void queue_close();
    logic [BYTE_W-1:0] check;
    check = FILL - (byte_sum + TRL_A + TRL_B);
    wire_bytes_q.push_back('{value: check, last: 1'b0});
    wire_bytes_q.push_back('{value: TRL_A, last: 1'b0});
    wire_bytes_q.push_back('{value: TRL_B, last: 1'b1});
    frame_open = 1'b0;
    data_left  = '0;
    byte_sum   = '0;
  endfunction

  function automatic void predict_frame_bytes(logic op, logic [BYTE_W-1:0] rw,
                                              logic [BYTE_W-1:0] mcmd,
                                              logic [BYTE_W-1:0] scmd,
                                              logic [LEN_W-1:0] len,
                                              logic [BYTE_W-1:0] data);
    int i;
    if (op == OP_START) begin
      if (len > MAX_DATA) return;
      frame_open = 1'b0;
      data_left  = '0;
      byte_sum   = '0;
      queue_summed(HDR_A);
      queue_summed(HDR_B);
      queue_summed(rw);
      queue_summed(mcmd);
      queue_summed(scmd);
      queue_summed(BYTE_W'(len));
      if (rw != '0 && len != '0) begin
        frame_open = 1'b1;
        data_left  = len;
      end else begin
        if (rw == '0) begin
          for (i = 0; i < len; i++) queue_summed(FILL);
        end
        queue_close();
      end
    end else if (frame_open && data_left != '0) begin
      queue_summed(data);
      data_left = data_left - 1'b1;
      if (data_left == '0) queue_close();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wire_bytes_q.delete();
      frame_open    = 1'b0;
      data_left     = '0;
      byte_sum      = '0;
      fail_count    = 0;
      pending_bytes = 0;
      bytes_checked = 0;
      frames_closed = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame_bytes(in_opcode, in_rw_flag, in_main_command, in_sub_command,
                            in_payload_length, in_payload_byte);
      end
      if (out_valid && !out_stall) begin
        if (wire_bytes_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte, expected none, got %02h end %0b",
                   $time, out_byte, out_frame_end);
        end else begin
          oldest = wire_bytes_q.pop_front();
          if (out_byte !== oldest.value) begin
            fail_count++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, oldest.value, out_byte);
          end
          if (out_frame_end !== oldest.last) begin
            fail_count++;
            $display("%0t: out_frame_end mismatch, expected %0b, got %0b",
                     $time, oldest.last, out_frame_end);
          end
        end
        bytes_checked++;
        if (out_frame_end) frames_closed++;
      end
      pending_bytes = wire_bytes_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import cfb_pkg::*;

  localparam int ITEM_TARGET  = 360;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_opcode;
  logic [BYTE_W-1:0] in_rw_flag;
  logic [BYTE_W-1:0] in_main_command;
  logic [BYTE_W-1:0] in_sub_command;
  logic [LEN_W-1:0]  in_payload_length;
  logic [BYTE_W-1:0] in_payload_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_frame_end;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int items_sent   = 0;
  int starts_sent  = 0;
  int noise_sent   = 0;
  int cycle_count  = 0;
  int fail_count;
  int pending_bytes;
  int bytes_checked;
  int frames_closed;

  command_frame_builder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_rw_flag        (in_rw_flag),
    .in_main_command   (in_main_command),
    .in_sub_command    (in_sub_command),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end)
  );

  frame_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_rw_flag        (in_rw_flag),
    .in_main_command   (in_main_command),
    .in_sub_command    (in_sub_command),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .fail_count        (fail_count),
    .pending_bytes     (pending_bytes),
    .bytes_checked     (bytes_checked),
    .frames_closed     (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic drive_item(input logic op, input logic [BYTE_W-1:0] rw,
                            input logic [BYTE_W-1:0] mcmd, input logic [BYTE_W-1:0] scmd,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_rw_flag        <= rw;
    in_main_command   <= mcmd;
    in_sub_command    <= scmd;
    in_payload_length <= len;
    in_payload_byte   <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic start_frame(input logic [BYTE_W-1:0] rw, input logic [BYTE_W-1:0] mcmd,
                             input logic [BYTE_W-1:0] scmd, input logic [LEN_W-1:0] len);
    drive_item(OP_START, rw, mcmd, scmd, len, BYTE_W'($urandom));
    starts_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data);
    drive_item(OP_DATA, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
               LEN_W'($urandom), data);
  endtask

  task automatic random_sequence();
    int kind;
    int len;
    int cut;
    int i;
    kind = $urandom_range(99);
    if (kind < 60) begin
      // write frame, now and then cut short so the next start abandons it
      len = ($urandom_range(9) == 0) ? $urandom_range(MAX_DATA, 7) : $urandom_range(6, 1);
      cut = ($urandom_range(9) == 0) ? $urandom_range(len - 1, 0) : len;
      start_frame(BYTE_W'($urandom_range(255, 1)), BYTE_W'($urandom), BYTE_W'($urandom),
                  LEN_W'(len));
      for (i = 0; i < cut; i++) send_byte(BYTE_W'($urandom));
    end else if (kind < 80) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(MAX_DATA, 5) : $urandom_range(4, 0);
      start_frame('0, BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'(len));
    end else if (kind < 88) begin
      start_frame(BYTE_W'($urandom_range(255, 1)), BYTE_W'($urandom), BYTE_W'($urandom),
                  '0);
    end else if (kind < 94) begin
      start_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  LEN_W'($urandom_range((1 << LEN_W) - 1, MAX_DATA + 1)));
      noise_sent++;
    end else begin
      send_byte(BYTE_W'($urandom));
      noise_sent++;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_START;
    in_rw_flag        = '0;
    in_main_command   = '0;
    in_sub_command    = '0;
    in_payload_length = '0;
    in_payload_byte   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct  = 14;
    stall_pct = 54;

    // directed corners
    send_byte('1);
    start_frame('0, '0, '0, '0);
    start_frame('1, '1, '1, '0);
    start_frame(8'h5a, 8'h12, 8'h34, LEN_W'(MAX_DATA + 1));
    start_frame(8'h01, '0, '0, '1);
    start_frame('0, 8'haa, 8'h55, LEN_W'(MAX_DATA));
    start_frame(8'h01, 8'h81, 8'h7e, LEN_W'(2));
    send_byte('1);
    send_byte('0);
    start_frame(8'h80, 8'hc3, 8'h3c, LEN_W'(3));
    send_byte(8'h01);
    start_frame(8'hfe, 8'h0f, 8'hf0, LEN_W'(1));
    send_byte(8'ha5);
    send_byte(8'h5a);
    start_frame('1, '0, '1, LEN_W'(1));
    send_byte('1);

    while (items_sent - noise_sent < ITEM_TARGET / 3) random_sequence();
    idle_pct  = 54;
    stall_pct = 14;
    while (items_sent - noise_sent < 2 * ITEM_TARGET / 3) random_sequence();
    idle_pct  = 0;
    stall_pct = 0;
    while (items_sent - noise_sent < ITEM_TARGET) random_sequence();

    in_valid <= 1'b0;
    wait (pending_bytes == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("drove %0d items: %0d frame starts, %0d stray or oversized",
             items_sent, starts_sent, noise_sent);
    $display("checked %0d wire bytes over %0d closed frames, %0d errors",
             bytes_checked, frames_closed, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
